FILE: sv/pidc_pkg.sv
// Shared constants and types for the PID controller block.
`default_nettype none

package pidc_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 23;
	localparam int SUM_W      = LIMIT_W + 1;
	localparam int DRIVE_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_GAIN_P = 3'd1,
		REG_GAIN_I = 3'd2,
		REG_GAIN_D = 3'd3,
		REG_LIMIT  = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		MODE_POS = 1'b0,
		MODE_INC = 1'b1
	} mode_t;

endpackage

`default_nettype wire

FILE: sv/pidc_if.sv
// Valid/ready channel interfaces for sample input and drive output.
`default_nettype none

interface pidc_in_if #(
	parameter int SAMPLE_WIDTH = pidc_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] target;
	logic signed [SAMPLE_WIDTH-1:0] measured;

	modport source (output valid, output target, output measured, input ready);
	modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pidc_out_if;
	import pidc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

FILE: sv/pid_controller_pos_inc.sv
// PID controller, positional or incremental form, one sample per beat.
// The block takes one (target, measured) beat per clock while the output side is not stalled
// and returns one drive beat per sample, through the input register and then the result register.
// Samples land in the input register; once the result register is free or moves on, the error,
// error sum clamp, three Q8.8 gain multiplies, the saturating sum and the state update run in
// one pass into the result register, so the state feedback loop through that pass sets the clock
// rate. The input side keeps accepting while a finished drive waits, as long as the input register
// is free or moves on. Gains, mode and the integral limit are to be written by the user through
// the cfg port while no sample is in flight; the block itself does not enforce this. State (error
// history, error sum, output accumulator) clears on reset only.
`default_nettype none

module pid_controller_pos_inc #(
	parameter int SAMPLE_WIDTH   = pidc_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	pidc_in_if.sink                               in_ch,
	pidc_out_if.source                            out_ch,
	input  wire logic                             cfg_we,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pidc_pkg::*;

	localparam int EW  = SAMPLE_WIDTH + 1;
	localparam int D1W = EW + 1;
	localparam int D2W = EW + 2;
	localparam int SPW = ((SUM_W > EW) ? SUM_W : EW) + 1;
	localparam int OW  = (SUM_W > D2W) ? SUM_W : D2W;
	localparam int MW  = GAIN_W + OW;
	localparam int RW  = MW + 2;
	localparam int AW  = RW + 1;

	localparam logic signed [AW-1:0] DMAX = {{(AW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [AW-1:0] DMIN = {{(AW-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

	function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] c;
		if (v > DMAX) begin
			c = DMAX;
		end else if (v < DMIN) begin
			c = DMIN;
		end else begin
			c = v;
		end
		return c[DRIVE_W-1:0];
	endfunction

	// configuration
	mode_t                     mode_q;
	logic signed [GAIN_W-1:0]  gain_p_q;
	logic signed [GAIN_W-1:0]  gain_i_q;
	logic signed [GAIN_W-1:0]  gain_d_q;
	logic        [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_POS;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			limit_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= mode_t'(cfg_data[0]);
				REG_GAIN_P: gain_p_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I: gain_i_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D: gain_d_q <= cfg_data[GAIN_W-1:0];
				REG_LIMIT:  limit_q  <= cfg_data[LIMIT_W-1:0];
				default:    ;
			endcase
		end
	end

	// handshake
	logic valid_s1;
	logic valid_s2;
	logic adv;
	logic fire;

	assign adv          = !valid_s2 || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || adv;
	assign fire         = valid_s1 && adv;
	assign out_ch.valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	logic signed [SAMPLE_WIDTH-1:0] target_s1;
	logic signed [SAMPLE_WIDTH-1:0] measured_s1;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			target_s1   <= in_ch.target;
			measured_s1 <= in_ch.measured;
		end
	end

	// controller state
	logic signed [EW-1:0]      prev_err_q;
	logic signed [EW-1:0]      pprev_err_q;
	logic signed [SUM_W-1:0]   err_sum_q;
	logic signed [DRIVE_W-1:0] accum_q;

	// datapath
	logic signed [EW-1:0]      err;
	logic signed [D1W-1:0]     d1;
	logic signed [D2W-1:0]     d2;
	logic signed [SPW-1:0]     sum_raw;
	logic signed [SPW-1:0]     lim_pos;
	logic signed [SPW-1:0]     lim_neg;
	logic signed [SPW-1:0]     sum_clamp;
	logic signed [SUM_W-1:0]   sum_next;
	logic signed [OW-1:0]      op_p;
	logic signed [OW-1:0]      op_i;
	logic signed [OW-1:0]      op_d;
	logic signed [MW-1:0]      prod_p;
	logic signed [MW-1:0]      prod_i;
	logic signed [MW-1:0]      prod_d;
	logic signed [RW-1:0]      total;
	logic signed [AW-1:0]      acc_sum;
	logic signed [DRIVE_W-1:0] drive_next;

	always_comb begin
		err     = EW'(target_s1) - EW'(measured_s1);
		d1      = D1W'(err) - D1W'(prev_err_q);
		d2      = D2W'(err) - (D2W'(prev_err_q) <<< 1) + D2W'(pprev_err_q);
		sum_raw = SPW'(err_sum_q) + SPW'(err);
		lim_pos = SPW'(signed'({1'b0, limit_q}));
		lim_neg = -lim_pos;
		if (sum_raw > lim_pos) begin
			sum_clamp = lim_pos;
		end else if (sum_raw < lim_neg) begin
			sum_clamp = lim_neg;
		end else begin
			sum_clamp = sum_raw;
		end
		sum_next = sum_clamp[SUM_W-1:0];

		if (mode_q == MODE_INC) begin
			op_p = OW'(d1);
			op_i = OW'(err);
			op_d = OW'(d2);
		end else begin
			op_p = OW'(err);
			op_i = OW'(sum_next);
			op_d = OW'(d1);
		end

		prod_p = MW'(op_p) * MW'(gain_p_q);
		prod_i = MW'(op_i) * MW'(gain_i_q);
		prod_d = MW'(op_d) * MW'(gain_d_q);

		total = RW'(prod_p >>> GAIN_FRAC_BITS) + RW'(prod_i >>> GAIN_FRAC_BITS)
		      + RW'(prod_d >>> GAIN_FRAC_BITS);
		acc_sum = AW'(total) + AW'(accum_q);

		if (mode_q == MODE_INC) begin
			drive_next = sat_drive(acc_sum);
		end else begin
			drive_next = sat_drive(AW'(total));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			pprev_err_q <= '0;
			err_sum_q   <= '0;
			accum_q     <= '0;
		end else if (fire) begin
			prev_err_q <= err;
			if (mode_q == MODE_INC) begin
				pprev_err_q <= prev_err_q;
				accum_q     <= drive_next;
			end else begin
				err_sum_q <= sum_next;
			end
		end
	end

	logic signed [DRIVE_W-1:0] drive_s2;

	always_ff @(posedge clk) begin
		if (fire) begin
			drive_s2 <= drive_next;
		end
	end

	assign out_ch.drive = drive_s2;

endmodule

`default_nettype wire

FILE: sv/pidc_checker.sv
// Port-level checks for the PID controller, bound to the top level.
`default_nettype none

module pidc_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [pidc_pkg::DRIVE_W-1:0] drive
);
	import pidc_pkg::*;

	// stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive))
		else $error("drive beat dropped or changed while stalled");

	// an accepted sample reaches the output through the input and result registers when the sink takes beats
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("accepted sample did not produce a drive beat");

	// one sample buffered behind a stalled result fills the block
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && in_valid && in_ready) ##1 !out_ready |-> !in_ready)
		else $error("input accepted beyond buffer capacity");

	// nothing comes out, right after reset or later, without an accepted sample
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("drive beat without a sample");

endmodule

bind pid_controller_pos_inc pidc_checker u_pidc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.drive     (out_ch.drive)
);

`default_nettype wire
